// File: src/trpm_pkg.sv
// Package: shared constants and types for the tree rank path mapper.
`timescale 1ns / 1ps
package trpm_pkg;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WIDE_W  = 34;
   localparam logic [WIDE_W-1:0] SAT_CAP = 34'h2_0000_0000;

   // digit slots in a packed path and bits per digit
   localparam int unsigned MAX_DIGITS = 8;
   localparam int unsigned DIGIT_BITS = 4;

   localparam logic [1:0] CSR_BRANCH_BASE = 2'd0;
   localparam logic [1:0] CSR_LEVEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_TOP_COUNT   = 2'd2;

   localparam logic OP_RANK_TO_PATH = 1'b0;
   localparam logic OP_PATH_TO_RANK = 1'b1;

   typedef struct packed {
      logic [4:0]  branch_base;
      logic [3:0]  level_count;
      logic [15:0] top_count;
   } csr_type;

   // saturating add of two wide values
   function automatic logic [WIDE_W-1:0] sat_add(input logic [WIDE_W-1:0] a,
                                                  input logic [WIDE_W-1:0] b);
      logic [WIDE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SAT_CAP}) ? SAT_CAP : s[WIDE_W-1:0];
   endfunction
endpackage

// File: src/trpm_req_if.sv
// Interfaces: request and response channels of the tree rank path mapper.
`timescale 1ns / 1ps
interface trpm_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] rank_in;
   logic [3:0]  path_len_in;
   logic [15:0] top_index_in;
   logic [31:0] digits_in;
   modport source (output valid, op, rank_in, path_len_in, top_index_in, digits_in,
                   input ready);
   modport sink   (input valid, op, rank_in, path_len_in, top_index_in, digits_in,
                   output ready);
endinterface

interface trpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rank_out;
   logic [3:0]  path_len_out;
   logic [15:0] top_index_out;
   logic [31:0] digits_out;
   logic        range_error;
   modport source (output valid, rank_out, path_len_out, top_index_out, digits_out,
                   range_error, input ready);
   modport sink   (input valid, rank_out, path_len_out, top_index_out, digits_out,
                   range_error, output ready);
endinterface

// File: src/tree_rank_path_mapper_core.sv
// Top level: tree rank path mapper with sequencer, shared MAC and divider.
`timescale 1ns / 1ps
// Converts a linear rank into a forest path (op 0) or a path back to its rank
// (op 1). Requests arrive as beats on req, results leave as beats on rsp.
// csr writes set branch base, level count and tree count; write only while idle.
//
// One beat is taken at a time; req.ready is low while a beat is in work.
// The tree size is a geometric sum over L-1 levels, then the range check runs.
// Op 0 then works in the bit-serial divider, searches the level in up to L-2
// steps and runs one divide per emitted digit; op 1 folds the path in the MAC.
// The bit-serial divider dominates. The result is held in an output register
// until rsp.ready; a stalled receiver holds the block in that state.
// Reset returns the registers to base 2, four levels, one tree and idles.
module tree_rank_path_mapper_core
   import trpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   trpm_req_if.sink    req,
   trpm_rsp_if.source  rsp
);
   localparam int MAXL = MAX_DIGITS + 2;
   localparam int BMAX = 1 << DIGIT_BITS;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_TREE  = 10'b0000000010,
      S_CHECK = 10'b0000000100,
      S_DIV   = 10'b0000001000,
      S_LEVEL = 10'b0000010000,
      S_DIGIT = 10'b0000100000,
      S_PBASE = 10'b0001000000,
      S_PGEO  = 10'b0010000000,
      S_PACC  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   csr_type   csr_ff, csr_in;

   logic [4:0]        eb;
   logic [3:0]        el;
   logic [WIDE_W-1:0] ntree_ff, ntree_in, s_ff, s_in, acc_ff, acc_in, rem_ff, rem_in;
   logic [3:0]        cnt_ff, cnt_in, m_ff, m_in;
   logic              op_ff, op_in, err_ff, err_in, wait_ff, wait_in;
   logic [31:0]       rank_ff, rank_in, dig_ff, dig_in, pdig_ff, pdig_in;
   logic [3:0]        plen_ff, plen_in;
   logic [15:0]       top_ff, top_in, ptop_ff, ptop_in;
   logic [WIDE_W-1:0] mac_a, mac_c, mac_y;
   logic [16:0]       mac_b;
   logic              div_start, div_done;
   logic [31:0]       div_n, div_q;
   logic [WIDE_W-1:0] div_d, div_r;
   logic [WIDE_W-1:0] total;
   logic [WIDE_W-1:0] pacc_sum;
   logic [DIGIT_BITS-1:0] cur_dig;
   logic [5:0]        dpos;

   trpm_mac u_mac (.clock, .a(mac_a), .b(mac_b), .c(mac_c), .y_ff(mac_y));
   trpm_div u_div (.clock, .reset, .start(div_start), .dividend(div_n),
                   .divisor(div_d), .done_ff(div_done), .quot_ff(div_q),
                   .rem_ff(div_r));

   // clamp base and levels
   always_comb begin
      eb = csr_ff.branch_base;
      if (eb < 5'd2) eb = 5'd2;
      if ({27'd0, eb} > BMAX) eb = 5'(BMAX);
      el = csr_ff.level_count;
      if (el < 4'd2) el = 4'd2;
      if ({28'd0, el} > MAXL) el = 4'(MAXL);
   end

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BRANCH_BASE: csr_in.branch_base = csr_wdata[4:0];
            CSR_LEVEL_COUNT: csr_in.level_count = csr_wdata[3:0];
            CSR_TOP_COUNT:   csr_in.top_count   = csr_wdata;
            default:         csr_in = csr_ff;
         endcase
      end
   end

   // total is the registered MAC output
   assign total = mac_y;

   always_comb begin
      state_in = state_ff;
      ntree_in = ntree_ff; s_in = s_ff; acc_in = acc_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; m_in = m_ff; op_in = op_ff; err_in = err_ff; wait_in = 1'b0;
      rank_in = rank_ff; dig_in = dig_ff; plen_in = plen_ff; top_in = top_ff;
      pdig_in = pdig_ff; ptop_in = ptop_ff;
      mac_a = s_ff; mac_b = {12'd0, eb}; mac_c = {{(WIDE_W-1){1'b0}}, 1'b1};
      div_start = 1'b0; div_n = rank_ff; div_d = ntree_ff;
      dpos = '0; cur_dig = '0; pacc_sum = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in = req.op; rank_in = req.rank_in; plen_in = req.path_len_in;
               ptop_in = req.top_index_in; pdig_in = req.digits_in;
               err_in = 1'b0; dig_in = '0; top_in = '0;
               s_in = '0; cnt_in = el - 4'd1; wait_in = 1'b0;
               state_in = S_TREE;
            end
         end
         S_TREE: begin
            // tree size: geometric sum over L-1 levels, one MAC step per level
            mac_a = s_ff;
            if (wait_ff) begin
               s_in = mac_y;
               if (cnt_ff == 4'd0) begin
                  ntree_in = mac_y;
                  state_in = S_CHECK;
                  wait_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff - 4'd1;
               wait_in = 1'b1;
            end
         end
         S_CHECK: begin
            // total = T*top_count+1 for op 0, base = T*top+1 for op 1
            mac_a = ntree_ff;
            mac_b = {1'b0, (op_ff == OP_RANK_TO_PATH) ? csr_ff.top_count : ptop_ff};
            if (wait_ff) begin
               wait_in = 1'b0;
            end else if (op_ff == OP_RANK_TO_PATH) begin
               if ({2'd0, rank_ff} >= total) begin
                  err_in = 1'b1; state_in = S_DONE;
               end else if (rank_ff == 32'd0) begin
                  plen_in = 4'd1; state_in = S_DONE;
               end else begin
                  rank_in = rank_ff - 32'd1;
                  div_n = rank_ff - 32'd1;
                  div_start = 1'b1; wait_in = 1'b1;
                  state_in = S_DIV;
               end
            end else begin
               acc_in = total;
               if (plen_ff == 4'd0 || plen_ff > el ||
                   (plen_ff >= 4'd2 && ptop_ff >= csr_ff.top_count)) begin
                  err_in = 1'b1; state_in = S_DONE;
               end else if (plen_ff == 4'd1) begin
                  rank_in = '0; state_in = S_DONE;
               end else begin
                  m_in = plen_ff - 4'd2; cnt_in = '0; s_in = '0;
                  state_in = S_PGEO; wait_in = 1'b1;
               end
            end
         end
         S_DIV: begin
            div_n = rank_ff;
            if (!wait_ff && div_done) begin
               top_in = div_q[15:0]; rem_in = div_r; plen_in = 4'd2;
               if (div_r == '0) begin
                  state_in = S_DONE;
               end else begin
                  s_in = '0; m_in = '0; wait_in = 1'b1; state_in = S_LEVEL;
               end
            end
         end
         S_LEVEL: begin
            // find largest m with S(m) <= rem
            mac_a = s_ff;
            if (wait_ff) begin
               wait_in = 1'b0;
            end else if (m_ff < el - 4'd2 && mac_y <= rem_ff) begin
               s_in = mac_y; m_in = m_ff + 4'd1; wait_in = 1'b1;
               mac_a = mac_y;
            end else begin
               rem_in = rem_ff - s_ff; cnt_in = m_ff; plen_in = 4'd2 + m_ff;
               if (m_ff == 4'd0) begin
                  state_in = S_DONE;
               end else begin
                  div_n = 32'(rem_ff - s_ff); div_d = {29'd0, eb};
                  div_start = 1'b1; wait_in = 1'b1; state_in = S_DIGIT;
               end
            end
         end
         S_DIGIT: begin
            div_n = rem_ff[31:0]; div_d = {29'd0, eb};
            if (!wait_ff && div_done) begin
               dpos = 6'(({2'd0, cnt_ff} - 6'd1) * DIGIT_BITS);
               if (dpos < 6'd32) begin
                  dig_in = dig_ff | (32'(div_r[DIGIT_BITS-1:0]) << dpos[4:0]);
               end
               rem_in = {2'd0, div_q}; cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  state_in = S_DONE;
               end else begin
                  div_n = div_q; div_start = 1'b1; wait_in = 1'b1;
               end
            end
         end
         S_PGEO: begin
            // add S(m), one MAC step per term
            mac_a = s_ff;
            if (wait_ff) begin
               wait_in = 1'b0;
            end else if (cnt_ff < m_ff) begin
               s_in = mac_y; cnt_in = cnt_ff + 4'd1; wait_in = 1'b1;
               mac_a = mac_y;
            end else begin
               acc_in = sat_add(acc_ff, s_ff); s_in = '0; cnt_in = '0;
               wait_in = 1'b1; state_in = S_PACC;
            end
         end
         S_PACC: begin
            // Horner over the digits
            dpos = 6'({2'd0, cnt_ff} * DIGIT_BITS);
            if (dpos < 6'd32) begin
               cur_dig = pdig_ff[dpos[4:0] +: DIGIT_BITS];
            end
            mac_a = s_ff; mac_c = {{(WIDE_W-DIGIT_BITS){1'b0}}, cur_dig};
            if (wait_ff) begin
               wait_in = 1'b0;
            end else if (cnt_ff < m_ff) begin
               if ({1'b0, cur_dig} >= eb) err_in = 1'b1;
               s_in = mac_y; cnt_in = cnt_ff + 4'd1; wait_in = 1'b1;
            end else begin
               pacc_sum = sat_add(acc_ff, s_ff);
               acc_in = pacc_sum;
               if (pacc_sum > {2'd0, 32'hFFFF_FFFF}) err_in = 1'b1;
               rank_in = pacc_sum[31:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, csr and wait flag take reset; the datapath registers load without it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         csr_ff   <= '{branch_base: 5'd2, level_count: 4'd4, top_count: 16'd1};
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         csr_ff   <= csr_in;
         wait_ff  <= wait_in;
      end
      ntree_ff <= ntree_in; s_ff <= s_in; acc_ff <= acc_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; m_ff <= m_in; op_ff <= op_in; err_ff <= err_in;
      rank_ff <= rank_in; dig_ff <= dig_in; plen_ff <= plen_in; top_ff <= top_in;
      pdig_ff <= pdig_in; ptop_ff <= ptop_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_DONE);
   assign rsp.range_error   = err_ff;
   assign rsp.rank_out      = (err_ff || op_ff == OP_RANK_TO_PATH) ? 32'd0 : rank_ff;
   assign rsp.path_len_out  = (err_ff || op_ff == OP_PATH_TO_RANK) ? 4'd1 : plen_ff;
   assign rsp.top_index_out = (err_ff || op_ff == OP_PATH_TO_RANK) ? 16'd0 : top_ff;
   assign rsp.digits_out    = (err_ff || op_ff == OP_PATH_TO_RANK) ? 32'd0 : dig_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready and valid together");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule

// File: src/trpm_mac.sv
// Shared multiply-accumulate unit: registered saturating a*b+c.
`timescale 1ns / 1ps
module trpm_mac
   import trpm_pkg::*;
(
   input  logic              clock,
   input  logic [WIDE_W-1:0] a,
   input  logic [16:0]       b,
   input  logic [WIDE_W-1:0] c,
   output logic [WIDE_W-1:0] y_ff
);
   logic [WIDE_W+16:0] prod;
   logic [WIDE_W-1:0]  y_in;

   always_comb begin
      prod = {17'd0, a} * {{WIDE_W{1'b0}}, b};
      if (prod > {17'd0, SAT_CAP}) begin
         y_in = SAT_CAP;
      end else begin
         y_in = sat_add(prod[WIDE_W-1:0], c);
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end
endmodule

// File: src/trpm_div.sv
// Restoring divider: one quotient bit a cycle, 32-bit dividend.
`timescale 1ns / 1ps
module trpm_div
   import trpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [WIDE_W-1:0] divisor,
   output logic              done_ff,
   output logic [31:0]       quot_ff,
   output logic [WIDE_W-1:0] rem_ff
);
   logic              busy_ff, busy_in, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [31:0]       quot_in;
   logic [WIDE_W-1:0] rem_in, dsr_ff, dsr_in;
   logic [WIDE_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[31]} - {1'b0, dsr_ff};
         if (!trial[WIDE_W]) begin
            rem_in  = trial[WIDE_W-1:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[WIDE_W-2:0], quot_ff[31]};
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end
endmodule

// File: verif/testbench.sv
// Testbench: self-checking regression of the tree rank path mapper core.
`timescale 1ns / 1ps
module testbench
   import trpm_pkg::*;
();

   typedef struct {
      logic        op;
      logic [31:0] rank;
      logic [3:0]  plen;
      logic [15:0] top;
      logic [31:0] digits;
   } mapper_req_type;

   typedef struct {
      logic [31:0] rank;
      logic [3:0]  plen;
      logic [15:0] top;
      logic [31:0] digits;
      logic        range_err;
   } mapper_rsp_type;

   localparam longint unsigned CAP = 64'd1 << 33;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_BRANCH_BASE;
   logic [15:0] csr_wdata = '0;

   trpm_req_if req ();
   trpm_rsp_if rsp ();

   tree_rank_path_mapper_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp       (rsp)
   );

   always #2 clock = ~clock;

   // shadow copy of the registers
   logic [4:0]  base_reg = 5'd2;
   logic [3:0]  levels_reg = 4'd4;
   logic [15:0] trees_reg = 16'd1;

   mapper_req_type pending_beats[$];
   mapper_rsp_type expected_paths[$];
   mapper_req_type cur_beat;
   bit          in_flight = 1'b0;
   int          fail_count = 0;
   int unsigned cyc = 0;

   function automatic longint unsigned cap_add(longint unsigned a, longint unsigned b);
      longint unsigned r;
      r = a + b;
      return (r > CAP) ? CAP : r;
   endfunction

   function automatic longint unsigned cap_mul(longint unsigned a, longint unsigned b);
      if (a == 0 || b == 0) return 0;
      if (a > CAP / b) return CAP;
      return (a * b > CAP) ? CAP : a * b;
   endfunction

   function automatic longint unsigned geo_sum(longint unsigned b, longint unsigned m);
      longint unsigned s;
      s = 0;
      for (longint unsigned i = 0; i < m; i++) s = cap_add(cap_mul(s, b), 1);
      return s;
   endfunction

   function automatic longint unsigned eff_base();
      if (base_reg < 2) return 2;
      if (base_reg > 16) return 16;
      return base_reg;
   endfunction

   function automatic longint unsigned eff_levels();
      if (levels_reg < 2) return 2;
      if (levels_reg > 10) return 10;
      return levels_reg;
   endfunction

   function automatic longint unsigned tree_size();
      return geo_sum(eff_base(), eff_levels() - 1);
   endfunction

   function automatic mapper_rsp_type map_beat(mapper_req_type it);
      mapper_rsp_type  o;
      longint unsigned b, l, nt, total, r, rem, s, nxt, idx, acc, d, rk, m;
      bit              err;
      b = eff_base();
      l = eff_levels();
      nt = geo_sum(b, l - 1);
      o = '{rank: '0, plen: 4'd1, top: '0, digits: '0, range_err: 1'b0};
      err = 1'b0;
      if (it.op == OP_RANK_TO_PATH) begin
         total = cap_add(cap_mul(nt, trees_reg), 1);
         if (it.rank >= total) begin
            err = 1'b1;
         end else if (it.rank != 0) begin
            r = it.rank - 1;
            rem = r % nt;
            o.top = 16'(r / nt);
            o.plen = 4'd2;
            if (rem != 0) begin
               m = 0;
               s = 0;
               while (m < l - 2) begin
                  nxt = cap_add(cap_mul(s, b), 1);
                  if (nxt > rem) break;
                  s = nxt;
                  m++;
               end
               idx = rem - s;
               // least significant digit sits in the last slot
               for (longint unsigned k = m; k > 0; k--) begin
                  d = idx % b;
                  idx = idx / b;
                  o.digits[(k-1)*4 +: 4] = d[3:0];
               end
               o.plen = 4'(2 + m);
            end
         end
      end else begin
         if (it.plen == 0 || it.plen > l || (it.plen >= 2 && it.top >= trees_reg)) begin
            err = 1'b1;
         end else if (it.plen >= 2) begin
            m = it.plen - 2;
            rk = cap_add(cap_add(cap_mul(nt, it.top), 1), geo_sum(b, m));
            acc = 0;
            for (longint unsigned k = 0; k < m; k++) begin
               d = it.digits[k*4 +: 4];
               if (d >= b) err = 1'b1;
               acc = cap_add(cap_mul(acc, b), d);
            end
            rk = cap_add(rk, acc);
            if (rk > 64'hFFFF_FFFF) err = 1'b1;
            o.rank = rk[31:0];
         end
      end
      if (err) o = '{rank: '0, plen: 4'd1, top: '0, digits: '0, range_err: 1'b1};
      return o;
   endfunction

   function automatic mapper_req_type rand_beat();
      mapper_req_type  it;
      longint unsigned b, l, total, lim;
      int              sel;
      b = eff_base();
      l = eff_levels();
      it.op = 1'($urandom_range(0, 1));
      it.rank = $urandom;
      it.plen = 4'($urandom);
      it.top = 16'($urandom);
      it.digits = $urandom;
      sel = $urandom_range(0, 9);
      if (it.op == OP_RANK_TO_PATH) begin
         total = cap_add(cap_mul(tree_size(), trees_reg), 1);
         lim = (total > 64'h1_0000_0000) ? 64'h1_0000_0000 : total;
         if (sel == 1) it.rank = 32'(lim - 1);
         else if (sel == 2 && total <= 64'hFFFF_FFFF) it.rank = 32'(total);
         else if (sel > 2) it.rank = 32'({$urandom, $urandom} % lim);
      end else if (sel > 1) begin
         // well-formed path, every nibble a random digit below the base; sel 2 may spoil one
         it.plen = 4'($urandom_range(2, 32'(l)));
         if (trees_reg != 0) it.top = 16'($urandom % trees_reg);
         for (int k = 0; k < 8; k++) it.digits[k*4 +: 4] = 4'($urandom_range(0, 32'(b - 1)));
         if (sel == 2) it.digits[$urandom_range(0, 7)*4 +: 4] = 4'($urandom_range(32'(b - 1), 15));
      end
      return it;
   endfunction

   task automatic queue_beat(logic op, logic [31:0] rank, logic [3:0] plen,
                             logic [15:0] top, logic [31:0] digits);
      pending_beats.insert(pending_beats.size(),
                           '{op: op, rank: rank, plen: plen, top: top, digits: digits});
   endtask

   task automatic report_mismatch(string what, mapper_rsp_type got, mapper_rsp_type want);
      $display("mismatch %s: got %h/%0d/%h/%h/%b want %h/%0d/%h/%h/%b", what,
               got.rank, got.plen, got.top, got.digits, got.range_err,
               want.rank, want.plen, want.top, want.digits, want.range_err);
      fail_count++;
   endtask

   task automatic top_count_set(logic [15:0] val);
      trees_reg = val;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BRANCH_BASE: base_reg = val[4:0];
         CSR_LEVEL_COUNT: levels_reg = val[3:0];
         default:         top_count_set(val);
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_beats.size() == 0 && !in_flight && expected_paths.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // Idling pattern steps with the cycle count through none, sender, receiver, both.
   function automatic bit roll_idle(bit sender_side);
      int mode;
      mode = (cyc / 1500) % 4;
      if (mode == 3) return $urandom_range(0, 99) < 26;
      if (mode == 1 && sender_side) return $urandom_range(0, 99) < 52;
      if (mode == 2 && !sender_side) return $urandom_range(0, 99) < 52;
      return 1'b0;
   endfunction

   always @(posedge clock) cyc <= cyc + 1;

   // Request driver: launch a new beat at the falling edge once the last one went.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!in_flight) begin
         if (pending_beats.size() != 0 && !roll_idle(1'b1)) begin
            cur_beat = pending_beats.pop_front();
            req.op <= cur_beat.op;
            req.rank_in <= cur_beat.rank;
            req.path_len_in <= cur_beat.plen;
            req.top_index_in <= cur_beat.top;
            req.digits_in <= cur_beat.digits;
            req.valid <= 1'b1;
            in_flight = 1'b1;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Accept: predict the result of each beat taken by the block.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready && in_flight) begin
         expected_paths.insert(expected_paths.size(), map_beat(cur_beat));
         in_flight = 1'b0;
      end
   end

   // Response side: stall at random, check every beat against the oldest prediction.
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !roll_idle(1'b0);
   end

   always @(posedge clock) begin
      mapper_rsp_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rank: rsp.rank_out, plen: rsp.path_len_out, top: rsp.top_index_out,
                 digits: rsp.digits_out, range_err: rsp.range_error};
         if (expected_paths.size() == 0) begin
            report_mismatch("unexpected beat", got, got);
         end else begin
            want = expected_paths.pop_front();
            if (got.rank !== want.rank) report_mismatch("rank_out", got, want);
            if (got.plen !== want.plen) report_mismatch("path_len_out", got, want);
            if (got.top !== want.top) report_mismatch("top_index_out", got, want);
            if (got.digits !== want.digits) report_mismatch("digits_out", got, want);
            if (got.range_err !== want.range_err) report_mismatch("range_error", got, want);
         end
      end
   end

   initial begin
      logic [15:0] cfg_list[12][3];
      req.valid = 1'b0;
      req.op = OP_RANK_TO_PATH;
      req.rank_in = '0;
      req.path_len_in = '0;
      req.top_index_in = '0;
      req.digits_in = '0;
      rsp.ready = 1'b0;
      cfg_list = '{'{2, 4, 1}, '{2, 2, 1}, '{16, 10, 65535}, '{16, 10, 1},
                   '{3, 5, 7}, '{2, 10, 65535}, '{0, 0, 0}, '{1, 15, 300},
                   '{31, 11, 2}, '{17, 1, 65535}, '{7, 6, 1000}, '{10, 3, 40000}};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats on the reset settings: seven ranks per tree, eight in all
      queue_beat(OP_RANK_TO_PATH, 32'd0, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_RANK_TO_PATH, 32'd1, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_RANK_TO_PATH, 32'd2, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_RANK_TO_PATH, 32'd7, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_RANK_TO_PATH, 32'd8, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_RANK_TO_PATH, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd0, 16'd0, 32'd0);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd1, 16'hFFFF, 32'hFFFF_FFFF);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd2, 16'd0, 32'd0);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd2, 16'd1, 32'd0);
      queue_beat(OP_PATH_TO_RANK, 32'hFFFF_FFFF, 4'd4, 16'd0, 32'h0000_0011);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd4, 16'd0, 32'hFFFF_FF01);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd4, 16'd0, 32'h0000_0020);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd5, 16'd0, 32'd0);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'hF, 16'd0, 32'd0);
      queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd3, 16'hFFFF, 32'd1);
      wait_drained();

      // every setting, extremes and clamped values among them
      for (int c = 0; c < 12; c++) begin
         write_reg(CSR_BRANCH_BASE, cfg_list[c][0]);
         write_reg(CSR_LEVEL_COUNT, cfg_list[c][1]);
         write_reg(CSR_TOP_COUNT, cfg_list[c][2]);
         if (c == 2) begin
            // the deepest rank and two paths whose ranks overflow 32 bits
            queue_beat(OP_RANK_TO_PATH, 32'hFFFF_FFFF, 4'd0, 16'd0, 32'd0);
            queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd10, 16'hFFFE, 32'hFFFF_FFFF);
            queue_beat(OP_PATH_TO_RANK, 32'd0, 4'd10, 16'd0, 32'hFFFF_FFFF);
         end
         for (int n = 0; n < 120; n++) pending_beats.insert(pending_beats.size(), rand_beat());
         wait_drained();
      end

      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(64'd16_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
